### rtl/vfec_pkg.sv
// Types, constants and CRC helper for the velocity frame encoder.
// Used by every module of the encoder; depends on nothing.
package vfec_pkg;

    // Input command: two signed speeds
    typedef struct packed {
        logic signed [15:0] linear_speed;
        logic signed [15:0] turn_speed;
    } t_cmd;

    // One frame byte on the output channel
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_out;

    // Queued job: command plus its finished CRC
    typedef struct packed {
        t_cmd        cmd;
        logic [15:0] crc;
    } t_job;

    // Frame constants
    localparam logic [7:0]  Hdr0Byte  = 8'hAA;
    localparam logic [7:0]  Hdr1Byte  = 8'h55;
    localparam logic [7:0]  TypeByte  = 8'h60;
    localparam logic [7:0]  TrailByte = 8'hDD;
    localparam logic [15:0] CrcInit   = 16'hFFFF;
    localparam logic [15:0] CrcPoly   = 16'hA001;

    // Byte positions in the frame
    localparam logic [3:0] PosHdr0  = 4'd0;
    localparam logic [3:0] PosHdr1  = 4'd1;
    localparam logic [3:0] PosType  = 4'd2;
    localparam logic [3:0] PosLinHi = 4'd3;
    localparam logic [3:0] PosLinLo = 4'd4;
    localparam logic [3:0] PosTrnHi = 4'd5;
    localparam logic [3:0] PosTrnLo = 4'd6;
    localparam logic [3:0] PosCrcHi = 4'd7;
    localparam logic [3:0] PosCrcLo = 4'd8;
    localparam logic [3:0] PosTrail = 4'd9;

    // Speed bytes run through the CRC one per cycle
    localparam logic [1:0] SpeedByteLast = 2'd3;

    // Job queue depth
    localparam int unsigned QueueDepth = 2;

    // One byte of reflected CRC-16 (poly A001), eight bit steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] acc;
        acc = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (acc[0]) begin
                acc = (acc >> 1) ^ CrcPoly;
            end else begin
                acc = acc >> 1;
            end
        end
        return acc;
    endfunction

    // CRC after the three fixed header bytes
    localparam logic [15:0] CrcPrefix =
        crc_byte(crc_byte(crc_byte(CrcInit, Hdr0Byte), Hdr1Byte), TypeByte);

endpackage

### rtl/vfec_front.sv
// Front end: accepts a command and folds its four speed bytes into the CRC.
// Depends on vfec_pkg; pushes finished jobs into vfec_queue.
module vfec_front import vfec_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cmd i_cmd,
    output logic o_push_valid,
    input  logic i_push_ready,
    output t_job o_push_job
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_PUSH = 3'b100
    } t_state;

    t_state      r_state, n_state;
    t_cmd        r_cmd, n_cmd;
    logic [15:0] r_crc, n_crc;
    logic [1:0]  r_idx, n_idx;
    logic [7:0]  sel_byte;
    logic        accept;

    // Take a new command when idle or while the finished one leaves
    assign o_ready = (r_state == S_IDLE) || ((r_state == S_PUSH) && i_push_ready);
    assign accept  = i_valid && o_ready;

    assign o_push_valid = (r_state == S_PUSH);
    assign o_push_job   = '{cmd: r_cmd, crc: r_crc};

    // Pick the speed byte for this CRC step
    always_comb begin
        case (r_idx)
            2'd0:    sel_byte = r_cmd.linear_speed[15:8];
            2'd1:    sel_byte = r_cmd.linear_speed[7:0];
            2'd2:    sel_byte = r_cmd.turn_speed[15:8];
            default: sel_byte = r_cmd.turn_speed[7:0];
        endcase
    end

    // Sequence: load, four CRC steps, push
    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_crc   = r_crc;
        n_idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd   = i_cmd;
                    n_crc   = CrcPrefix;
                    n_idx   = 2'd0;
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_crc = crc_byte(r_crc, sel_byte);
                n_idx = r_idx + 2'd1;
                if (r_idx == SpeedByteLast) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (i_push_ready) begin
                    if (accept) begin
                        n_cmd   = i_cmd;
                        n_crc   = CrcPrefix;
                        n_idx   = 2'd0;
                        n_state = S_CALC;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state resets, payload just loads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
        r_cmd <= n_cmd;
        r_crc <= n_crc;
    end

    // A job is only offered after all four steps
    a_push_after_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH) && !$past(r_state == S_PUSH) |-> $past(r_idx == SpeedByteLast))
        else $error("front pushed before CRC finished");

endmodule

### rtl/vfec_queue.sv
// Short job queue between the front end and the byte serializer.
// Depends on vfec_pkg for the job type and depth.
module vfec_queue import vfec_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_job i_push_job,
    output logic o_pop_valid,
    input  logic i_pop,
    output t_job o_pop_job
);

    localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int unsigned CntW = $clog2(QueueDepth + 1);

    t_job            r_slot [QueueDepth];
    logic [PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            push, pop;

    assign o_push_ready = (r_count != CntW'(QueueDepth));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_slot[r_rd_ptr];

    assign push = i_push_valid && o_push_ready;
    assign pop  = i_pop && o_pop_valid;

    // Write slot
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_job;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(QueueDepth))
        else $error("queue count out of range");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(push && !pop) |-> r_count == $past(r_count) + 1'b1)
        else $error("queue count missed a push");

endmodule

### rtl/vfec_back.sv
// Back end: walks the head job through the ten frame bytes into an output register.
// Depends on vfec_pkg; pops jobs from vfec_queue.
module vfec_back import vfec_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_job_valid,
    input  t_job i_job,
    output logic o_pop,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_frame
);

    logic [3:0] r_pos;
    logic       r_out_valid;
    t_out       r_out;
    logic       load;
    logic [7:0] cur_byte;

    // Refill the output register when empty or being taken
    assign load  = i_job_valid && (!r_out_valid || i_ready);
    assign o_pop = load && (r_pos == PosTrail);

    assign o_valid = r_out_valid;
    assign o_frame = r_out;

    // Select the frame byte at the current position
    always_comb begin
        unique case (r_pos)
            PosHdr0:  cur_byte = Hdr0Byte;
            PosHdr1:  cur_byte = Hdr1Byte;
            PosType:  cur_byte = TypeByte;
            PosLinHi: cur_byte = i_job.cmd.linear_speed[15:8];
            PosLinLo: cur_byte = i_job.cmd.linear_speed[7:0];
            PosTrnHi: cur_byte = i_job.cmd.turn_speed[15:8];
            PosTrnLo: cur_byte = i_job.cmd.turn_speed[7:0];
            PosCrcHi: cur_byte = i_job.crc[15:8];
            PosCrcLo: cur_byte = i_job.crc[7:0];
            default:  cur_byte = TrailByte;
        endcase
    end

    // Advance position and drive the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= PosHdr0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_pos       <= (r_pos == PosTrail) ? PosHdr0 : r_pos + 4'd1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (load) begin
            r_out.frame_byte <= cur_byte;
            r_out.last_byte  <= (r_pos == PosTrail);
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PosTrail)
        else $error("frame position out of range");

    a_last_is_trailer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.last_byte |-> r_out.frame_byte == TrailByte)
        else $error("last byte flag on a byte that is not the trailer");

endmodule

### rtl/velocity_frame_encoder_crc16.sv
// Channel    | Direction | Handshake                  | Payload
// command    | in        | i_in_valid / o_in_ready    | i_cmd   (t_cmd)
// frame byte | out       | o_out_valid / i_out_ready  | o_frame (t_out)
//
// Each command yields ten output bytes, one per cycle while i_out_ready is high,
// so the sustained command rate is set by the byte serializer on the output
// channel. The front end takes four CRC byte steps and a push per command, and
// can accept the next command while the finished job is taken by the queue.
// Reset is synchronous, active low, and clears control state only.
// A 2-deep job queue lets the front keep taking commands while output stalls.
//
// Top level of the velocity frame encoder; depends on vfec_pkg, vfec_front,
// vfec_queue and vfec_back.
module velocity_frame_encoder_crc16_core import vfec_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_cmd i_cmd,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_frame
);

    logic push_valid, push_ready, job_valid, pop;
    t_job push_job, head_job;

    // Accept commands and compute CRC
    vfec_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_cmd        (i_cmd),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_job   (push_job)
    );

    // Hold finished jobs
    vfec_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_job   (push_job),
        .o_pop_valid  (job_valid),
        .i_pop        (pop),
        .o_pop_job    (head_job)
    );

    // Serialize frames
    vfec_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_frame     (o_frame)
    );

endmodule
